@@ design/iee_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types, codes and helpers of the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

    localparam int DefValueDepth    = 32;
    localparam int DefOperatorDepth = 32;

    localparam int OpW     = 3;
    localparam int OperW   = 16;
    localparam int StatW   = 3;
    localparam int ValW    = 32;
    localparam int DvdW    = 48;
    localparam int DivCntW = 6;
    localparam logic [DivCntW-1:0] DivSteps = DivCntW'(DvdW);

    typedef enum logic [OpW-1:0] {
        TOK_NUM   = 3'd0,
        TOK_ADD   = 3'd1,
        TOK_SUB   = 3'd2,
        TOK_MUL   = 3'd3,
        TOK_DIV   = 3'd4,
        TOK_OPEN  = 3'd5,
        TOK_CLOSE = 3'd6,
        TOK_END   = 3'd7
    } tok_t;

    typedef enum logic [StatW-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_MALFORMED = 3'd3,
        ST_DIVZERO   = 3'd4
    } stat_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_LOOP, S_OPCHK, S_APPLY, S_RD_A, S_EXEC,
        S_MUL, S_DIV, S_DIVFIN, S_PUSH, S_FIN, S_OUT
    } state_t;

    typedef enum logic [4:0] {
        A_NONE, A_PUSH_NUM, A_PUSH_TOK, A_PUSH_OPEN, A_ERR_EMPTY, A_ERR_MALF,
        A_RD_OPR, A_POP_OPR, A_APPLY, A_RD_A, A_EXEC, A_MUL_FIN, A_DIV_STEP,
        A_DIV_FIN, A_PUSH_RES, A_FIN, A_LOAD_OUT
    } act_t;

    typedef struct packed {
        logic latch;
        logic set_seen;
        act_t act;
    } cmd_t;

    typedef struct packed {
        tok_t tok;
        tok_t otop;
        logic err_zero;
        logic seen;
        logic ocnt_zero;
        logic vcnt_lt2;
        logic b_zero;
        logic div_last;
        logic out_free;
    } sts_t;

    function automatic logic [1:0] prio_of(input tok_t code);
        logic [1:0] p;
        p = 2'd0;
        if (code == TOK_MUL || code == TOK_DIV) p = 2'd2;
        else if (code == TOK_ADD || code == TOK_SUB) p = 2'd1;
        return p;
    endfunction

endpackage
`default_nettype wire

@@ design/iee_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iee_ctrl
// Token sequencer: unwinds the operator stack and steps the arithmetic unit.
// ----------------------------------------------------------------------------
module iee_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_fire,
    output iee_pkg::cmd_t      cmd,
    input  wire iee_pkg::sts_t sts,
    output logic               idle
);
    import iee_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    assign idle = (state_reg == S_IDLE);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) state_next = S_DISPATCH;
            S_DISPATCH: begin
                if (sts.tok == TOK_END) state_next = S_LOOP;
                else if (!sts.err_zero || sts.tok == TOK_NUM || sts.tok == TOK_OPEN)
                    state_next = S_IDLE;
                else state_next = S_LOOP;
            end
            S_LOOP: begin
                if (!sts.err_zero || sts.ocnt_zero)
                    state_next = (sts.tok == TOK_END) ? S_FIN : S_IDLE;
                else state_next = S_OPCHK;
            end
            S_OPCHK: begin
                priority if (sts.tok == TOK_CLOSE)
                    state_next = (sts.otop == TOK_OPEN) ? S_IDLE : S_APPLY;
                else if (sts.tok == TOK_END)
                    state_next = (sts.otop == TOK_OPEN) ? S_LOOP : S_APPLY;
                else
                    state_next = (prio_of(sts.otop) >= prio_of(sts.tok)) ? S_APPLY : S_IDLE;
            end
            S_APPLY: state_next = sts.vcnt_lt2 ? S_LOOP : S_RD_A;
            S_RD_A:  state_next = S_EXEC;
            S_EXEC: begin
                unique case (sts.otop)
                    TOK_ADD, TOK_SUB: state_next = S_PUSH;
                    TOK_MUL:          state_next = S_MUL;
                    TOK_DIV:          state_next = sts.b_zero ? S_LOOP : S_DIV;
                    default:          state_next = S_LOOP;
                endcase
            end
            S_MUL:    state_next = S_PUSH;
            S_DIV:    if (sts.div_last) state_next = S_DIVFIN;
            S_DIVFIN: state_next = S_PUSH;
            S_PUSH:   state_next = S_LOOP;
            S_FIN:    state_next = S_OUT;
            S_OUT:    if (sts.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd = '{latch: 1'b0, set_seen: 1'b0, act: A_NONE};
        unique case (state_reg)
            S_IDLE: cmd.latch = in_fire;
            S_DISPATCH: begin
                if (sts.tok != TOK_END) begin
                    cmd.set_seen = 1'b1;
                    if (sts.err_zero) begin
                        if (sts.tok == TOK_NUM)       cmd.act = A_PUSH_NUM;
                        else if (sts.tok == TOK_OPEN) cmd.act = A_PUSH_OPEN;
                    end
                end else if (sts.err_zero && !sts.seen) begin
                    cmd.act = A_ERR_EMPTY;
                end
            end
            S_LOOP: begin
                if (sts.err_zero) begin
                    if (!sts.ocnt_zero) cmd.act = A_RD_OPR;
                    else if (sts.tok == TOK_CLOSE) cmd.act = A_ERR_MALF;
                    else if (sts.tok != TOK_END) cmd.act = A_PUSH_TOK;
                end
            end
            S_OPCHK: begin
                priority if (sts.tok == TOK_CLOSE) begin
                    if (sts.otop == TOK_OPEN) cmd.act = A_POP_OPR;
                end else if (sts.tok == TOK_END) begin
                    if (sts.otop == TOK_OPEN) cmd.act = A_ERR_MALF;
                end else if (prio_of(sts.otop) < prio_of(sts.tok)) begin
                    cmd.act = A_PUSH_TOK;
                end
            end
            S_APPLY:  cmd.act = A_APPLY;
            S_RD_A:   cmd.act = A_RD_A;
            S_EXEC:   cmd.act = A_EXEC;
            S_MUL:    cmd.act = A_MUL_FIN;
            S_DIV:    cmd.act = A_DIV_STEP;
            S_DIVFIN: cmd.act = A_DIV_FIN;
            S_PUSH:   cmd.act = A_PUSH_RES;
            S_FIN:    cmd.act = A_FIN;
            S_OUT:    if (sts.out_free) cmd.act = A_LOAD_OUT;
            default:  cmd.act = A_NONE;
        endcase
    end

endmodule
`default_nettype wire

@@ design/iee_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iee_dp
// Stacks, fixed-point arithmetic unit, radix-2 divider and result register.
// ----------------------------------------------------------------------------
module iee_dp #(
    parameter int VALUE_DEPTH    = iee_pkg::DefValueDepth,
    parameter int OPERATOR_DEPTH = iee_pkg::DefOperatorDepth
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [iee_pkg::OpW-1:0]      in_op,
    input  wire logic signed [iee_pkg::OperW-1:0] in_operand,
    input  wire iee_pkg::cmd_t                cmd,
    output iee_pkg::sts_t                     sts,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [iee_pkg::OperW-1:0]  out_result,
    output logic [iee_pkg::StatW-1:0]         out_status
);
    import iee_pkg::*;

    localparam int VAW = $clog2(VALUE_DEPTH);
    localparam int VCW = $clog2(VALUE_DEPTH + 1);
    localparam int OAW = $clog2(OPERATOR_DEPTH);
    localparam int OCW = $clog2(OPERATOR_DEPTH + 1);
    localparam logic [VCW-1:0] VFull = VCW'(VALUE_DEPTH);
    localparam logic [OCW-1:0] OFull = OCW'(OPERATOR_DEPTH);
    localparam logic signed [ValW-1:0] VMax = {1'b0, {(ValW-1){1'b1}}};
    localparam logic signed [ValW-1:0] VMin = {1'b1, {(ValW-1){1'b0}}};

    logic [ValW-1:0] vmem [VALUE_DEPTH];
    tok_t            omem [OPERATOR_DEPTH];

    tok_t                  tok_reg;
    logic signed [OperW-1:0] operand_reg;
    logic [VCW-1:0]        vcnt_reg;
    logic [OCW-1:0]        ocnt_reg;
    logic                  seen_reg;
    stat_t                 err_reg;
    logic signed [ValW-1:0] vrd_reg, b_reg, res_reg;
    tok_t                  ord_reg;
    logic signed [2*ValW-1:0] prod_reg;
    logic [DvdW-1:0]       dvd_reg;
    logic [ValW-1:0]       dsr_reg, rem_reg;
    logic                  neg_reg;
    logic [DivCntW-1:0]    dcnt_reg;
    logic                  ovalid_reg;
    logic signed [OperW-1:0] ores_reg;
    stat_t                 ostat_reg;

    logic [VCW-1:0] vtop1, vtop2;
    logic [OCW-1:0] otop1;
    assign vtop1 = vcnt_reg - VCW'(1);
    assign vtop2 = vcnt_reg - VCW'(2);
    assign otop1 = ocnt_reg - OCW'(1);

    // add / subtract with saturation
    logic signed [ValW:0] sum_w;
    logic signed [ValW-1:0] sum_sat;
    always_comb begin
        if (ord_reg == TOK_SUB) sum_w = {vrd_reg[ValW-1], vrd_reg} - {b_reg[ValW-1], b_reg};
        else                    sum_w = {vrd_reg[ValW-1], vrd_reg} + {b_reg[ValW-1], b_reg};
        if (sum_w[ValW] != sum_w[ValW-1]) sum_sat = sum_w[ValW] ? VMin : VMax;
        else                              sum_sat = sum_w[ValW-1:0];
    end

    // product scaled back, truncated toward zero, saturated
    logic signed [DvdW-1:0] mq;
    logic signed [ValW-1:0] mul_sat;
    always_comb begin
        mq = prod_reg[2*ValW-1:16];
        if (prod_reg[2*ValW-1] && (prod_reg[15:0] != 16'd0)) mq = mq + DvdW'(1);
        if (mq > DvdW'(signed'(VMax)))      mul_sat = VMax;
        else if (mq < DvdW'(signed'(VMin))) mul_sat = VMin;
        else                                mul_sat = mq[ValW-1:0];
    end

    // one restoring division step
    logic [ValW:0] dsh, ddif;
    assign dsh  = {rem_reg, dvd_reg[DvdW-1]};
    assign ddif = dsh - {1'b0, dsr_reg};

    logic signed [ValW-1:0] div_sat;
    always_comb begin
        if (neg_reg) begin
            if (dvd_reg > DvdW'(33'h0_8000_0000)) div_sat = VMin;
            else                                  div_sat = -signed'(dvd_reg[ValW-1:0]);
        end else begin
            if (dvd_reg > DvdW'(32'h7FFF_FFFF)) div_sat = VMax;
            else                                div_sat = dvd_reg[ValW-1:0];
        end
    end

    logic [ValW-1:0] abs_a, abs_b;
    assign abs_a = vrd_reg[ValW-1] ? ValW'(-vrd_reg) : ValW'(vrd_reg);
    assign abs_b = b_reg[ValW-1]   ? ValW'(-b_reg)   : ValW'(b_reg);

    logic signed [OperW-1:0] int_part;
    always_comb begin
        int_part = vrd_reg[ValW-1:16];
        if (vrd_reg[ValW-1] && (vrd_reg[15:0] != 16'd0)) int_part = int_part + OperW'(1);
    end

    // memories
    always_ff @(posedge aclk) begin
        unique case (cmd.act)
            A_PUSH_NUM: if (vcnt_reg != VFull)
                vmem[vcnt_reg[VAW-1:0]] <= {operand_reg, 16'd0};
            A_PUSH_RES: vmem[vcnt_reg[VAW-1:0]] <= res_reg;
            A_APPLY:    vrd_reg <= vmem[vtop1[VAW-1:0]];
            A_RD_A:     vrd_reg <= vmem[vtop2[VAW-1:0]];
            A_FIN:      vrd_reg <= vmem[0];
            default: ;
        endcase
        unique case (cmd.act)
            A_PUSH_TOK:  if (ocnt_reg != OFull) omem[ocnt_reg[OAW-1:0]] <= tok_reg;
            A_PUSH_OPEN: if (ocnt_reg != OFull) omem[ocnt_reg[OAW-1:0]] <= TOK_OPEN;
            A_RD_OPR:    ord_reg <= omem[otop1[OAW-1:0]];
            default: ;
        endcase
    end

    // arithmetic payload
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            tok_reg     <= tok_t'(in_op);
            operand_reg <= in_operand;
        end
        unique case (cmd.act)
            A_RD_A: b_reg <= vrd_reg;
            A_EXEC: begin
                res_reg  <= sum_sat;
                prod_reg <= vrd_reg * b_reg;
                dvd_reg  <= {abs_a, 16'd0};
                dsr_reg  <= abs_b;
                rem_reg  <= '0;
                neg_reg  <= vrd_reg[ValW-1] ^ b_reg[ValW-1];
                dcnt_reg <= DivSteps;
            end
            A_MUL_FIN: res_reg <= mul_sat;
            A_DIV_STEP: begin
                if (!ddif[ValW]) begin
                    rem_reg <= ddif[ValW-1:0];
                    dvd_reg <= {dvd_reg[DvdW-2:0], 1'b1};
                end else begin
                    rem_reg <= dsh[ValW-1:0];
                    dvd_reg <= {dvd_reg[DvdW-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg - DivCntW'(1);
            end
            A_DIV_FIN: res_reg <= div_sat;
            default: ;
        endcase
        if (cmd.act == A_LOAD_OUT) begin
            ostat_reg <= err_reg;
            ores_reg  <= (err_reg == ST_OK) ? int_part : '0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcnt_reg   <= '0;
            ocnt_reg   <= '0;
            seen_reg   <= 1'b0;
            err_reg    <= ST_OK;
            ovalid_reg <= 1'b0;
        end else begin
            if (cmd.act == A_LOAD_OUT)        ovalid_reg <= 1'b1;
            else if (ovalid_reg && out_ready) ovalid_reg <= 1'b0;
            if (cmd.set_seen) seen_reg <= 1'b1;
            unique case (cmd.act)
                A_PUSH_NUM: begin
                    if (vcnt_reg == VFull) err_reg <= ST_OVERFLOW;
                    else vcnt_reg <= vcnt_reg + VCW'(1);
                end
                A_PUSH_TOK, A_PUSH_OPEN: begin
                    if (ocnt_reg == OFull) err_reg <= ST_OVERFLOW;
                    else ocnt_reg <= ocnt_reg + OCW'(1);
                end
                A_ERR_EMPTY: err_reg <= ST_EMPTY;
                A_ERR_MALF:  err_reg <= ST_MALFORMED;
                A_POP_OPR:   ocnt_reg <= otop1;
                A_APPLY: begin
                    ocnt_reg <= otop1;
                    if (vcnt_reg < VCW'(2)) err_reg <= ST_MALFORMED;
                end
                A_EXEC: begin
                    vcnt_reg <= vtop2;
                    if (ord_reg == TOK_DIV) begin
                        if (b_reg == '0) err_reg <= ST_DIVZERO;
                    end else if (ord_reg != TOK_ADD && ord_reg != TOK_SUB &&
                                 ord_reg != TOK_MUL) begin
                        err_reg <= ST_MALFORMED;
                    end
                end
                A_PUSH_RES: vcnt_reg <= vcnt_reg + VCW'(1);
                A_FIN: if (err_reg == ST_OK && vcnt_reg != VCW'(1)) err_reg <= ST_MALFORMED;
                A_LOAD_OUT: begin
                    vcnt_reg   <= '0;
                    ocnt_reg   <= '0;
                    seen_reg   <= 1'b0;
                    err_reg    <= ST_OK;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        sts.tok       = tok_reg;
        sts.otop      = ord_reg;
        sts.err_zero  = (err_reg == ST_OK);
        sts.seen      = seen_reg;
        sts.ocnt_zero = (ocnt_reg == '0);
        sts.vcnt_lt2  = (vcnt_reg < VCW'(2));
        sts.b_zero    = (b_reg == '0);
        sts.div_last  = (dcnt_reg == DivCntW'(1));
        sts.out_free  = !ovalid_reg || out_ready;
    end

    assign out_valid  = ovalid_reg;
    assign out_result = ores_reg;
    assign out_status = ostat_reg;

    a_vcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vcnt_reg <= VFull) else $error("value count beyond depth");
    a_ocnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ocnt_reg <= OFull) else $error("operator count beyond depth");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.act == A_LOAD_OUT |=> vcnt_reg == '0 && ocnt_reg == '0 && !seen_reg && out_valid)
        else $error("state not cleared after result");

endmodule
`default_nettype wire

@@ design/infix_expression_evaluator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Two-stack infix evaluator over signed Q16.16 values, one token per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one token per transfer; s_tdata = {operand, op}.
//     op 0 number, 1..4 + - * /, 5 open, 6 close, 7 end.
//   m_ channel: one transfer per end token; m_tdata = {status, result}.
//   A number or open token is pushed from the dispatch state. An unwound
//   operator steps the loop, check, apply, read, execute and push states,
//   plus a multiply state for * and divide states for / (the divider retires
//   one quotient bit per cycle over 48 bits); an output state loads the result.
//   Only one token is in flight; s_tready is high while the sequencer idles.
//   The result sits in an output register, so the next token is taken while
//   the receiver stalls; a second result waits until the first is taken.
//   Reset (aresetn low, synchronous) empties both stacks, clears the error
//   and drops any pending result. Stack memories hold no reset value.
// ----------------------------------------------------------------------------
module infix_expression_evaluator #(
    parameter int VALUE_DEPTH    = iee_pkg::DefValueDepth,
    parameter int OPERATOR_DEPTH = iee_pkg::DefOperatorDepth
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [2:0] op, [18:3] operand, [23:19] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // [15:0] result, [18:16] status, [23:19] zero
);
    import iee_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic idle;
    logic in_fire;
    logic signed [OperW-1:0] res;
    logic [StatW-1:0] stat;

    // accept a token only while the sequencer is idle
    assign s_tready = idle;
    assign in_fire  = s_tvalid && idle;

    iee_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .cmd     (cmd),
        .sts     (sts),
        .idle    (idle)
    );

    iee_dp #(
        .VALUE_DEPTH    (VALUE_DEPTH),
        .OPERATOR_DEPTH (OPERATOR_DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_op      (s_tdata[2:0]),
        .in_operand (s_tdata[18:3]),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res),
        .out_status (stat)
    );

    // pack the result transfer, pad to whole bytes
    assign m_tdata = {5'd0, stat, res};

endmodule
`default_nettype wire

@@ bench/tb_infix_expression_evaluator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_infix_expression_evaluator
// Self-checking bench for the two-stack infix evaluator: a directed token
// table, then random expressions, noise and stack floods under four idling
// phases, scored against typed answers or a Q16.16 evaluator kept in the bench.
// ----------------------------------------------------------------------------
module tb_infix_expression_evaluator;
    import iee_pkg::*;

    localparam int VDEPTH = 32;
    localparam int ODEPTH = 32;
    localparam int NDIR   = 28;
    localparam int PHASE_TOKENS = 412;

    typedef struct {
        tok_t        op;
        logic [15:0] val;
        bit          typed;
        logic [15:0] res;
        stat_t       st;
    } row_t;

    typedef struct {
        logic [15:0] res;
        stat_t       st;
    } answer_t;

    typedef struct {
        tok_t        op;
        logic [15:0] val;
    } token_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // [2:0] op, [18:3] operand, [23:19] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // [15:0] result, [18:16] status, [23:19] zero

    infix_expression_evaluator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Directed tokens; expected answers typed in only where obvious.
    row_t dir_rows [NDIR] = '{
        '{TOK_END,   16'hffff, 1, 16'h0000, ST_EMPTY},
        '{TOK_NUM,   16'h7fff, 0, 16'h0, ST_OK},
        '{TOK_END,   16'h0000, 1, 16'h7fff, ST_OK},
        '{TOK_NUM,   16'h8000, 0, 16'h0, ST_OK},
        '{TOK_END,   16'h0000, 1, 16'h8000, ST_OK},
        '{TOK_NUM,   16'h0001, 0, 16'h0, ST_OK},
        '{TOK_DIV,   16'hffff, 0, 16'h0, ST_OK},
        '{TOK_NUM,   16'h0000, 0, 16'h0, ST_OK},
        '{TOK_END,   16'h0000, 1, 16'h0000, ST_DIVZERO},
        '{TOK_CLOSE, 16'h0000, 0, 16'h0, ST_OK},
        '{TOK_END,   16'h0000, 1, 16'h0000, ST_MALFORMED},
        '{TOK_OPEN,  16'hffff, 0, 16'h0, ST_OK},
        '{TOK_NUM,   16'h0005, 0, 16'h0, ST_OK},
        '{TOK_END,   16'h0000, 1, 16'h0000, ST_MALFORMED},
        '{TOK_NUM,   16'h0002, 0, 16'h0, ST_OK},
        '{TOK_ADD,   16'h0000, 0, 16'h0, ST_OK},
        '{TOK_NUM,   16'h0003, 0, 16'h0, ST_OK},
        '{TOK_MUL,   16'h0000, 0, 16'h0, ST_OK},
        '{TOK_NUM,   16'h0004, 0, 16'h0, ST_OK},
        '{TOK_END,   16'h0000, 0, 16'h0, ST_OK},
        '{TOK_OPEN,  16'h0000, 0, 16'h0, ST_OK},
        '{TOK_NUM,   16'h0007, 0, 16'h0, ST_OK},
        '{TOK_SUB,   16'h0000, 0, 16'h0, ST_OK},
        '{TOK_NUM,   16'hffff, 0, 16'h0, ST_OK},
        '{TOK_CLOSE, 16'hffff, 0, 16'h0, ST_OK},
        '{TOK_DIV,   16'h0000, 0, 16'h0, ST_OK},
        '{TOK_NUM,   16'h0002, 0, 16'h0, ST_OK},
        '{TOK_END,   16'h0000, 0, 16'h0, ST_OK}
    };

    // ---------------- evaluator state kept by the bench ----------------
    logic signed [31:0] val_stk [VDEPTH];
    tok_t               opr_stk [ODEPTH];
    int                 val_cnt;
    int                 opr_cnt;
    bit                 any_token;
    stat_t              err_code;

    answer_t answer_q[$];
    token_t  token_q[$];
    int      fail_cnt;
    int      token_cnt;
    int      answer_cnt;
    int      src_idle;
    int      sink_stall;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic int rank_of(input tok_t t);
        if (t == TOK_MUL || t == TOK_DIV) return 2;
        if (t == TOK_ADD || t == TOK_SUB) return 1;
        return 0;
    endfunction

    function void flag_error(input stat_t s);
        if (err_code == ST_OK) err_code = s;
    endfunction

    function void push_val(input logic signed [31:0] v);
        if (val_cnt >= VDEPTH) begin
            flag_error(ST_OVERFLOW);
        end else begin
            val_stk[val_cnt] = v;
            val_cnt++;
        end
    endfunction

    function void push_opr(input tok_t t);
        if (opr_cnt >= ODEPTH) begin
            flag_error(ST_OVERFLOW);
        end else begin
            opr_stk[opr_cnt] = t;
            opr_cnt++;
        end
    endfunction

    // Pop one operator and fold the two top values; deeper entry is left.
    function void fold_top();
        tok_t   t;
        longint a, b, r;
        if (opr_cnt == 0) return;
        opr_cnt--;
        t = opr_stk[opr_cnt];
        if (val_cnt < 2) begin
            flag_error(ST_MALFORMED);
            return;
        end
        b = val_stk[val_cnt-1];
        a = val_stk[val_cnt-2];
        val_cnt -= 2;
        case (t)
            TOK_ADD: r = a + b;
            TOK_SUB: r = a - b;
            TOK_MUL: r = (a * b) / 65536;
            TOK_DIV: begin
                if (b == 0) begin
                    flag_error(ST_DIVZERO);
                    return;
                end
                r = (a * 65536) / b;
            end
            default: begin
                flag_error(ST_MALFORMED);
                return;
            end
        endcase
        push_val(clamp32(r));
    endfunction

    // Advance the evaluator by one token; returns 1 with an answer on end.
    function bit eval_token(input tok_t t, input logic [15:0] v, output answer_t ans);
        longint w;
        ans.res = '0;
        ans.st  = ST_OK;
        if (t != TOK_END) begin
            any_token = 1'b1;
            if (err_code != ST_OK) return 0;
            case (t)
                TOK_NUM:  push_val({v, 16'h0000});
                TOK_OPEN: push_opr(TOK_OPEN);
                TOK_CLOSE: begin
                    while (err_code == ST_OK && opr_cnt > 0 && opr_stk[opr_cnt-1] != TOK_OPEN)
                        fold_top();
                    if (err_code == ST_OK) begin
                        if (opr_cnt == 0) flag_error(ST_MALFORMED);
                        else opr_cnt--;
                    end
                end
                default: begin
                    while (err_code == ST_OK && opr_cnt > 0 &&
                           rank_of(opr_stk[opr_cnt-1]) >= rank_of(t))
                        fold_top();
                    if (err_code == ST_OK) push_opr(t);
                end
            endcase
            return 0;
        end
        if (err_code == ST_OK && !any_token) flag_error(ST_EMPTY);
        while (err_code == ST_OK && opr_cnt > 0) begin
            if (opr_stk[opr_cnt-1] == TOK_OPEN) flag_error(ST_MALFORMED);
            else fold_top();
        end
        if (err_code == ST_OK && val_cnt != 1) flag_error(ST_MALFORMED);
        ans.st = err_code;
        if (err_code == ST_OK) begin
            w = longint'(val_stk[0]) / 65536;
            ans.res = w[15:0];
        end
        val_cnt = 0;
        opr_cnt = 0;
        any_token = 1'b0;
        err_code = ST_OK;
        return 1;
    endfunction

    // Offer one token, hold it until transferred, then run it through the bench evaluator.
    task automatic send_token(input tok_t t, input logic [15:0] v, input bit typed,
                              input answer_t typed_ans);
        answer_t ans;
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, v, t};
        do @(posedge aclk); while (!s_tready);
        token_cnt++;
        if (eval_token(t, v, ans)) begin
            if (typed) ans = typed_ans;
            answer_q.insert(answer_q.size(), ans);
        end
    endtask

    // Append one token to the pending run.
    function void add_token(input tok_t t, input logic [15:0] v);
        token_t tk;
        tk.op  = t;
        tk.val = v;
        token_q.insert(token_q.size(), tk);
    endfunction

    function automatic logic [15:0] rand_operand();
        int n;
        if ($urandom_range(9) == 0) return 16'($urandom);
        n = int'($urandom_range(24)) - 12;
        return 16'(n);
    endfunction

    function automatic tok_t rand_binop();
        return tok_t'($urandom_range(4, 1));
    endfunction

    // Queue one well-formed expression: terms, operators, nested parens.
    function void build_expr();
        int nterm, depth;
        nterm = $urandom_range(6, 1);
        depth = 0;
        for (int i = 0; i < nterm; i++) begin
            if (i > 0) add_token(rand_binop(), 16'($urandom));
            while ($urandom_range(3) == 0 && depth < 6) begin
                add_token(TOK_OPEN, 16'($urandom));
                depth++;
            end
            add_token(TOK_NUM, rand_operand());
            while (depth > 0 && $urandom_range(2) == 0) begin
                add_token(TOK_CLOSE, 16'($urandom));
                depth--;
            end
        end
        while (depth > 0) begin
            add_token(TOK_CLOSE, 16'($urandom));
            depth--;
        end
        add_token(TOK_END, 16'($urandom));
    endfunction

    // Queue a broken run: random tokens other than end, usually followed by an end token.
    function void build_noise();
        int n;
        n = $urandom_range(8, 1);
        for (int i = 0; i < n; i++) add_token(tok_t'($urandom_range(6)), rand_operand());
        if ($urandom_range(3) != 0) add_token(TOK_END, 16'($urandom));
    endfunction

    // Queue a flood near the depth of the value or the operator stack, which may overrun it.
    function void build_flood();
        tok_t t;
        int   n;
        t = $urandom_range(1) ? TOK_NUM : TOK_OPEN;
        n = $urandom_range(VDEPTH + 4, VDEPTH - 1);
        for (int i = 0; i < n; i++) add_token(t, rand_operand());
        add_token(TOK_END, 16'($urandom));
    endfunction

    task automatic drain();
        while (answer_q.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // Receiver: pick stalls and score every transfer on the result channel.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            answer_cnt++;
            if (answer_q.size() == 0) begin
                $display("%0t: expected no result, got result %h", $time, m_tdata);
                fail_cnt++;
            end else begin
                if (m_tdata[15:0] !== answer_q[0].res || m_tdata[18:16] !== answer_q[0].st ||
                    m_tdata[23:19] !== 5'd0) begin
                    $display({"%0t: mismatch expected result %0d status %0d,",
                              " got result %0d status %0d (tdata %h)"},
                             $time, $signed(answer_q[0].res), answer_q[0].st,
                             $signed(m_tdata[15:0]), m_tdata[18:16], m_tdata);
                    fail_cnt++;
                end
                void'(answer_q.pop_front());
            end
        end
        m_tready <= ($urandom_range(99) >= sink_stall);
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        answer_t ta;
        token_t  tk;
        int      pick;
        fail_cnt = 0;
        token_cnt = 0;
        answer_cnt = 0;
        src_idle = 0;
        sink_stall = 0;
        val_cnt = 0;
        opr_cnt = 0;
        any_token = 1'b0;
        err_code = ST_OK;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table.
        for (int i = 0; i < NDIR; i++) begin
            ta.res = dir_rows[i].res;
            ta.st  = dir_rows[i].st;
            send_token(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed, ta);
        end

        // Random phases: none, sender idle, receiver stall, both.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle = 0;  sink_stall = 0;  end
                1: begin src_idle = 79; sink_stall = 0;  end
                2: begin src_idle = 0;  sink_stall = 79; end
                default: begin src_idle = 27; sink_stall = 27; end
            endcase
            for (int n = 0; n < PHASE_TOKENS; ) begin
                pick = $urandom_range(99);
                if (pick < 80) build_expr();
                else if (pick < 95) build_noise();
                else build_flood();
                while (token_q.size() != 0) begin
                    tk = token_q.pop_front();
                    send_token(tk.op, tk.val, 1'b0, ta);
                    n++;
                end
            end
            // Close any half-built run so nothing carries into the pause.
            send_token(TOK_END, 16'h0000, 1'b0, ta);
            s_tvalid <= 1'b0;
            drain();
        end

        sink_stall = 0;
        s_tvalid <= 1'b0;
        drain();
        $display("Sent %0d tokens and scored %0d results over four idling phases,",
                 token_cnt, answer_cnt);
        $display("covering nested expressions, error runs and stack floods.");
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
